// File: sv/qbr_pkg.sv
// Shared types, constants and the sine table for the quad bounce/rotate block.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package qbr_pkg;

  localparam int NUM_VTX   = 4;
  localparam int VIDX_W    = 2;
  localparam int COORD_W   = 20;
  localparam int VEL_W     = 16;
  localparam int WIN_W     = 11;
  localparam int FRAC_W    = 8;
  localparam int ANG_W     = 10;
  localparam int DEG_W     = 9;
  localparam int REQ_W     = 2;
  localparam int TRIG_F    = 14;
  localparam int TRIG_W    = TRIG_F + 2;
  localparam int SIN_N     = 91;
  localparam int SIN_IDX_W = 7;

  // Stream word layout.
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 2 * NUM_VTX * COORD_W;

  // Command queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Configuration port.
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam logic REG_WIN_WIDTH  = 1'b0;
  localparam logic REG_WIN_HEIGHT = 1'b1;
  localparam logic [WIN_W-1:0] WIN_WIDTH_RST  = WIN_W'(1080);
  localparam logic [WIN_W-1:0] WIN_HEIGHT_RST = WIN_W'(720);

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Denominators (2k)(2k+1) of the successive Taylor terms.
  localparam longint unsigned TAYLOR_DIV [10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK     = 2'd0,
    REQ_ROTATE   = 2'd1,
    REQ_LOAD_VTX = 2'd2,
    REQ_LOAD_VEL = 2'd3
  } req_e;

  typedef struct packed {
    req_e                       op;
    logic [VIDX_W-1:0]          vidx;
    logic signed [COORD_W-1:0]  x;
    logic signed [COORD_W-1:0]  y;
    logic signed [VEL_W-1:0]    vx;
    logic signed [VEL_W-1:0]    vy;
    logic signed [TRIG_W-1:0]   sin_v;
    logic signed [TRIG_W-1:0]   cos_v;
  } cmd_t;

  typedef logic [TRIG_F:0] sin_tab_t [SIN_N];

  // Sine of 0..90 degrees: Taylor series to the x^21 term in unsigned Q30,
  // truncating each step, then rounded half up to TRIG_F fraction bits.
  function automatic sin_tab_t gen_sin_tab();
    sin_tab_t t;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned pos;
    longint unsigned neg;
    longint unsigned r;
    for (int d = 0; d < SIN_N; d++) begin
      x    = (PI_Q30 * 64'(d)) / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      pos  = x;
      neg  = 64'd0;
      for (int k = 1; k <= 10; k++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
        if (k[0]) begin
          neg = neg + term;
        end else begin
          pos = pos + term;
        end
      end
      r    = (pos > neg) ? (pos - neg) : 64'd0;
      r    = (r + (64'd1 << (29 - TRIG_F))) >> (30 - TRIG_F);
      t[d] = r[TRIG_F:0];
    end
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = gen_sin_tab();

endpackage

`default_nettype wire

// File: sv/qbr_front.sv
// Front end: takes input words, decodes the request and looks up sine and cosine.
// Depends on qbr_pkg; feeds the command queue.
`default_nettype none

module qbr_front (
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata: angle_deg, vertex_index, load_x, load_y, load_vel_x, load_vel_y, zero pad
  input  logic [qbr_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // tuser: req_type
  input  logic [qbr_pkg::REQ_W-1:0]     s_axis_tuser_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output qbr_pkg::cmd_t                 q_cmd_o
);
  import qbr_pkg::*;

  localparam int ANG_LO  = 0;
  localparam int VIDX_LO = ANG_LO + ANG_W;
  localparam int X_LO    = VIDX_LO + VIDX_W;
  localparam int Y_LO    = X_LO + COORD_W;
  localparam int VX_LO   = Y_LO + COORD_W;
  localparam int VY_LO   = VX_LO + VEL_W;

  localparam logic [DEG_W-1:0] DEG_90  = DEG_W'(90);
  localparam logic [DEG_W-1:0] DEG_180 = DEG_W'(180);
  localparam logic [DEG_W-1:0] DEG_270 = DEG_W'(270);
  localparam logic [DEG_W-1:0] DEG_360 = DEG_W'(360);

  // Quadrant folding onto the 0..90 degree table.
  function automatic logic signed [TRIG_W-1:0] sin_deg(input logic [DEG_W-1:0] a);
    logic [DEG_W-1:0]  f;
    logic              ng;
    logic [TRIG_W-1:0] mag;
    if (a <= DEG_90) begin
      f  = a;
      ng = 1'b0;
    end else if (a <= DEG_180) begin
      f  = DEG_180 - a;
      ng = 1'b0;
    end else if (a <= DEG_270) begin
      f  = a - DEG_180;
      ng = 1'b1;
    end else begin
      f  = DEG_360 - a;
      ng = 1'b1;
    end
    mag = {1'b0, SIN_TAB[f[SIN_IDX_W-1:0]]};
    return ng ? $signed(-mag) : $signed(mag);
  endfunction

  logic [ANG_W-1:0] angle_raw;
  logic [DEG_W-1:0] ang;
  logic [ANG_W-1:0] ang_p90;
  logic [DEG_W-1:0] cos_arg;

  always_comb begin
    angle_raw = s_axis_tdata_i[ANG_LO +: ANG_W];
    // Angles beyond a full turn act as no rotation.
    ang       = (angle_raw > ANG_W'(360)) ? '0 : angle_raw[DEG_W-1:0];
    ang_p90   = {1'b0, ang} + ANG_W'(90);
    cos_arg   = (ang_p90 >= ANG_W'(360)) ? DEG_W'(ang_p90 - ANG_W'(360))
                                         : ang_p90[DEG_W-1:0];
  end

  always_comb begin
    q_cmd_o.op    = req_e'(s_axis_tuser_i);
    q_cmd_o.vidx  = s_axis_tdata_i[VIDX_LO +: VIDX_W];
    q_cmd_o.x     = s_axis_tdata_i[X_LO +: COORD_W];
    q_cmd_o.y     = s_axis_tdata_i[Y_LO +: COORD_W];
    q_cmd_o.vx    = s_axis_tdata_i[VX_LO +: VEL_W];
    q_cmd_o.vy    = s_axis_tdata_i[VY_LO +: VEL_W];
    q_cmd_o.sin_v = sin_deg(ang);
    q_cmd_o.cos_v = sin_deg(cos_arg);
  end

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

endmodule

`default_nettype wire

// File: sv/qbr_fifo.sv
// Two-entry command queue between the front end and the execution back end.
// Depends on qbr_pkg for the command type.
`default_nettype none

module qbr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  qbr_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output qbr_pkg::cmd_t data_o
);
  import qbr_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic [QCNT_W-1:0] cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// File: sv/qbr_back.sv
// Back end: holds the quad state, runs ticks, loads and the pipelined rotation,
// and drives the output register. Depends on qbr_pkg.
`default_nettype none

module qbr_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           head_valid_i,
  input  qbr_pkg::cmd_t                  head_i,
  output logic                           pop_o,
  input  logic [qbr_pkg::WIN_W-1:0]      win_width_i,
  input  logic [qbr_pkg::WIN_W-1:0]      win_height_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [qbr_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);
  import qbr_pkg::*;

  localparam int SUM_W  = COORD_W + 1;
  localparam int DIFF_W = COORD_W + 3;
  localparam int CMP_W  = COORD_W + 3;
  localparam int PROD_W = TRIG_W + DIFF_W;
  localparam int ACC_W  = PROD_W + 2;

  localparam logic signed [ACC_W-1:0] C_MAX =
    {{(ACC_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] C_MIN =
    {{(ACC_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< TRIG_F;
  localparam logic signed [VEL_W-1:0] V_MAX = {1'b0, {(VEL_W - 1){1'b1}}};
  localparam logic signed [VEL_W-1:0] V_MIN = {1'b1, {(VEL_W - 1){1'b0}}};

  function automatic logic signed [COORD_W-1:0] sat_c(input logic signed [ACC_W-1:0] v);
    if (v > C_MAX) begin
      return C_MAX[COORD_W-1:0];
    end else if (v < C_MIN) begin
      return C_MIN[COORD_W-1:0];
    end
    return v[COORD_W-1:0];
  endfunction

  function automatic logic signed [VEL_W-1:0] neg_vel(input logic signed [VEL_W-1:0] v);
    return (v == V_MIN) ? V_MAX : -v;
  endfunction

  // Architectural state.
  logic signed [COORD_W-1:0] vx_q [NUM_VTX];
  logic signed [COORD_W-1:0] vy_q [NUM_VTX];
  logic signed [COORD_W-1:0] vx_d [NUM_VTX];
  logic signed [COORD_W-1:0] vy_d [NUM_VTX];
  logic signed [VEL_W-1:0]   velx_q, vely_q, velx_d, vely_d;

  // Rotation pipeline.
  logic                      r1_q, r2_q, r1_d, r2_d;
  logic signed [DIFF_W-1:0]  s1_dx_q [NUM_VTX];
  logic signed [DIFF_W-1:0]  s1_dy_q [NUM_VTX];
  logic signed [DIFF_W-1:0]  s1_dx_d [NUM_VTX];
  logic signed [DIFF_W-1:0]  s1_dy_d [NUM_VTX];
  logic signed [SUM_W-1:0]   s1_sx_q, s1_sy_q, s1_sx_d, s1_sy_d;
  logic signed [TRIG_W-1:0]  s1_sin_q, s1_cos_q;
  logic signed [PROD_W-1:0]  s2_pxc_q [NUM_VTX];
  logic signed [PROD_W-1:0]  s2_pxs_q [NUM_VTX];
  logic signed [PROD_W-1:0]  s2_pys_q [NUM_VTX];
  logic signed [PROD_W-1:0]  s2_pyc_q [NUM_VTX];
  logic signed [SUM_W-1:0]   s2_sx_q, s2_sy_q;

  logic                      can_load, done_rot, out_load, pop_rot;
  logic signed [CMP_W-1:0]   lim_x, lim_y, abs_x, abs_y, hi_x, hi_y;
  logic                      hit_x, hit_y;
  logic signed [VEL_W-1:0]   nvx, nvy;
  logic signed [COORD_W-1:0] tick_x [NUM_VTX];
  logic signed [COORD_W-1:0] tick_y [NUM_VTX];
  logic signed [COORD_W-1:0] rot_x [NUM_VTX];
  logic signed [COORD_W-1:0] rot_y [NUM_VTX];
  logic signed [ACC_W-1:0]   acc_x, acc_y;
  logic [OUT_DATA_W-1:0]     out_data_d;
  logic [OUT_DATA_W-1:0]     out_data_q;
  logic                      out_valid_q;

  // Handshake with the queue and the output register.
  always_comb begin
    can_load = !out_valid_q || m_axis_tready_i;
    done_rot = r2_q && can_load;
    pop_o    = head_valid_i && !r1_q && !r2_q &&
               ((head_i.op == REQ_ROTATE) || can_load);
    pop_rot  = pop_o && (head_i.op == REQ_ROTATE);
    out_load = (pop_o && (head_i.op != REQ_ROTATE)) || done_rot;
    r1_d     = pop_rot;
    r2_d     = r1_q ? 1'b1 : (done_rot ? 1'b0 : r2_q);
  end

  // Tick: per-axis edge test, velocity flip, then move.
  always_comb begin
    lim_x = CMP_W'({win_width_i, {FRAC_W{1'b0}}});
    lim_y = CMP_W'({win_height_i, {FRAC_W{1'b0}}});
    abs_x = velx_q[VEL_W-1] ? -CMP_W'(velx_q) : CMP_W'(velx_q);
    abs_y = vely_q[VEL_W-1] ? -CMP_W'(vely_q) : CMP_W'(vely_q);
    hi_x  = lim_x - abs_x;
    hi_y  = lim_y - abs_y;
    hit_x = 1'b0;
    hit_y = 1'b0;
    for (int i = 0; i < NUM_VTX; i++) begin
      if ((CMP_W'(vx_q[i]) >= hi_x) || (CMP_W'(vx_q[i]) <= abs_x)) begin
        hit_x = 1'b1;
      end
      if ((CMP_W'(vy_q[i]) >= hi_y) || (CMP_W'(vy_q[i]) <= abs_y)) begin
        hit_y = 1'b1;
      end
    end
    nvx = hit_x ? neg_vel(velx_q) : velx_q;
    nvy = hit_y ? neg_vel(vely_q) : vely_q;
    for (int i = 0; i < NUM_VTX; i++) begin
      tick_x[i] = sat_c(ACC_W'(vx_q[i]) + ACC_W'(nvx));
      tick_y[i] = sat_c(ACC_W'(vy_q[i]) + ACC_W'(nvy));
    end
  end

  // Rotation stage 1: center sum and doubled offsets from the current vertices.
  always_comb begin
    s1_sx_d = SUM_W'(vx_q[0]) + SUM_W'(vx_q[2]);
    s1_sy_d = SUM_W'(vy_q[0]) + SUM_W'(vy_q[2]);
    for (int i = 0; i < NUM_VTX; i++) begin
      s1_dx_d[i] = (DIFF_W'(vx_q[i]) <<< 1) - DIFF_W'(s1_sx_d);
      s1_dy_d[i] = (DIFF_W'(vy_q[i]) <<< 1) - DIFF_W'(s1_sy_d);
    end
  end

  // Rotation stage 3: combine products, round, halve and saturate.
  always_comb begin
    for (int i = 0; i < NUM_VTX; i++) begin
      acc_x = ACC_W'(s2_pxc_q[i]) - ACC_W'(s2_pxs_q[i]) +
              (ACC_W'(s2_sx_q) <<< TRIG_F) + RND;
      acc_y = ACC_W'(s2_pys_q[i]) + ACC_W'(s2_pyc_q[i]) +
              (ACC_W'(s2_sy_q) <<< TRIG_F) + RND;
      rot_x[i] = sat_c(acc_x >>> (TRIG_F + 1));
      rot_y[i] = sat_c(acc_y >>> (TRIG_F + 1));
    end
  end

  // Next architectural state.
  always_comb begin
    for (int i = 0; i < NUM_VTX; i++) begin
      vx_d[i] = vx_q[i];
      vy_d[i] = vy_q[i];
    end
    velx_d = velx_q;
    vely_d = vely_q;
    if (pop_o) begin
      case (head_i.op)
        REQ_TICK: begin
          velx_d = nvx;
          vely_d = nvy;
          for (int i = 0; i < NUM_VTX; i++) begin
            vx_d[i] = tick_x[i];
            vy_d[i] = tick_y[i];
          end
        end
        REQ_LOAD_VTX: begin
          vx_d[head_i.vidx] = head_i.x;
          vy_d[head_i.vidx] = head_i.y;
        end
        REQ_LOAD_VEL: begin
          velx_d = head_i.vx;
          vely_d = head_i.vy;
        end
        default: begin
        end
      endcase
    end
    if (done_rot) begin
      for (int i = 0; i < NUM_VTX; i++) begin
        vx_d[i] = rot_x[i];
        vy_d[i] = rot_y[i];
      end
    end
    for (int i = 0; i < NUM_VTX; i++) begin
      out_data_d[2 * i * COORD_W +: COORD_W]           = vx_d[i];
      out_data_d[(2 * i + 1) * COORD_W +: COORD_W]     = vy_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VTX; i++) begin
        vx_q[i] <= '0;
        vy_q[i] <= '0;
      end
      velx_q      <= '0;
      vely_q      <= '0;
      r1_q        <= 1'b0;
      r2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_VTX; i++) begin
        vx_q[i] <= vx_d[i];
        vy_q[i] <= vy_d[i];
      end
      velx_q <= velx_d;
      vely_q <= vely_d;
      r1_q   <= r1_d;
      r2_q   <= r2_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers of the rotation pipeline and the output word.
  always_ff @(posedge clk_i) begin
    if (pop_rot) begin
      s1_sx_q  <= s1_sx_d;
      s1_sy_q  <= s1_sy_d;
      s1_sin_q <= head_i.sin_v;
      s1_cos_q <= head_i.cos_v;
      for (int i = 0; i < NUM_VTX; i++) begin
        s1_dx_q[i] <= s1_dx_d[i];
        s1_dy_q[i] <= s1_dy_d[i];
      end
    end
    if (r1_q) begin
      s2_sx_q <= s1_sx_q;
      s2_sy_q <= s1_sy_q;
      for (int i = 0; i < NUM_VTX; i++) begin
        s2_pxc_q[i] <= PROD_W'(s1_cos_q) * PROD_W'(s1_dx_q[i]);
        s2_pxs_q[i] <= PROD_W'(s1_sin_q) * PROD_W'(s1_dy_q[i]);
        s2_pys_q[i] <= PROD_W'(s1_sin_q) * PROD_W'(s1_dx_q[i]);
        s2_pyc_q[i] <= PROD_W'(s1_cos_q) * PROD_W'(s1_dy_q[i]);
      end
    end
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

`default_nettype wire

// File: sv/quad_bounce_rotate.sv
// Quad bounce/rotate top level. A tick, vertex load or velocity load can be accepted
// every cycle while the queue is not full; with an empty queue its result word passes
// through the queue and the output register. A rotation holds the back end until it
// leaves the stage 1 and stage 2 registers and its result is loaded into the output
// register. Reset clears the vertices, the velocity and the queue; window width and
// height return to 1080 and 720 pixels.
`default_nettype none

module quad_bounce_rotate (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: angle_deg[9:0], vertex_index[11:10], load_x[31:12], load_y[51:32],
  //        load_vel_x[67:52], load_vel_y[83:68], zero pad[87:84]
  input  logic [qbr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: req_type[1:0]
  input  logic [qbr_pkg::REQ_W-1:0]      s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: out_x0, out_y0, out_x1, out_y1, out_x2, out_y2, out_x3, out_y3,
  //        20 bits each from bit 0 up
  output logic [qbr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qbr_pkg::APB_AW-1:0]     paddr,
  input  logic [qbr_pkg::APB_DW-1:0]     pwdata,
  output logic [qbr_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);
  import qbr_pkg::*;

  logic [WIN_W-1:0] win_width_q, win_height_q;
  logic             reg_wr;
  logic             q_push, q_full, q_pop, q_valid;
  cmd_t             q_in, q_head;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_width_q  <= WIN_WIDTH_RST;
      win_height_q <= WIN_HEIGHT_RST;
    end else if (reg_wr) begin
      case (paddr[2])
        REG_WIN_WIDTH:  win_width_q  <= pwdata[WIN_W-1:0];
        REG_WIN_HEIGHT: win_height_q <= pwdata[WIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_WIN_WIDTH:  prdata = APB_DW'(win_width_q);
      REG_WIN_HEIGHT: prdata = APB_DW'(win_height_q);
      default:        prdata = '0;
    endcase
  end

  qbr_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_cmd_o         (q_in)
  );

  qbr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_head)
  );

  qbr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (q_valid),
    .head_i          (q_head),
    .pop_o           (q_pop),
    .win_width_i     (win_width_q),
    .win_height_i    (win_height_q),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: sv/qbr_checker.sv
// Port-level checks for quad_bounce_rotate, attached by the bind at the end.
// Depends on qbr_pkg for widths.
`default_nettype none

module qbr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [qbr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic                           psel,
  input logic                           pready
);
  import qbr_pkg::*;

  // Queue, rotation stage and output register together hold at most four words.
  localparam logic [2:0] MAX_OPEN = 3'd4;

  logic [2:0] open_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + {2'b00, in_acc} - {2'b00, out_acc};
    end
  end

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (open_q != '0))
    else $error("result word with no outstanding request");

  a_bounded_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= MAX_OPEN)
    else $error("more requests outstanding than the block can hold");

  a_cfg_always_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("configuration port not ready");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed or dropped");

endmodule

bind quad_bounce_rotate qbr_checker u_qbr_checker (.*);

`default_nettype wire
